/* design/assert_macros.svh */
// Assertion macros shared by the resampler RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PHR_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PHR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PHR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PHR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/phr_pkg.sv */
// Package for the peak-hold display resampler: widths, codes, beat types and helpers.
// Used by phr_div, peak_hold_display_resampler, resampler_checker and testbench; depends on nothing.
package phr_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int NUM_W       = 2 * ADDR_W;
	localparam int DIV_W       = ADDR_W + SAMPLE_BITS;
	localparam int DVSR_W      = ADDR_W;
	localparam int PROD_W      = SAMPLE_BITS + ADDR_W + 2;
	localparam int DCNT_W      = $clog2(DIV_W);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	localparam logic CFG_INPUT_COUNT  = 1'b0;
	localparam logic CFG_OUTPUT_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] INPUT_COUNT_RST  = CNT_W'(4096);
	localparam logic [CNT_W-1:0] OUTPUT_COUNT_RST = CNT_W'(1024);

	typedef struct packed {
		logic                          cmd;
		logic [ADDR_W-1:0]             position;
		logic signed [SAMPLE_BITS-1:0] sample;
	} phr_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          status;
	} phr_out_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
	} phr_div_req_t;

	typedef struct packed {
		logic              done;
		logic              busy;
		logic [DIV_W-1:0]  quotient;
		logic [DVSR_W-1:0] remainder;
	} phr_div_rsp_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c < CNT_W'(2)) begin
			r = CNT_W'(2);
		end else if (c > CNT_W'(MAX_SAMPLES)) begin
			r = CNT_W'(MAX_SAMPLES);
		end
		return r;
	endfunction

endpackage

/* design/phr_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on phr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module phr_div import phr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  phr_div_req_t req,
	output phr_div_rsp_t rsp
);

	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVSR_W:0]   trial;
	logic              ge;
	logic [DVSR_W:0]   diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvsr_q};
	assign diff  = trial - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvsr_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvsr_q <= req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.busy      = busy_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`PHR_ASSERT_IMPLY(a_start_idle, req.start, !busy_q, "divider started while busy")
	`PHR_ASSERT_IMPLY(a_rem_bound, done_q, rem_q < dvsr_q, "remainder not below divisor")
	`PHR_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "divider done held longer than a cycle")

endmodule

/* design/peak_hold_display_resampler.sv */
// Top level of the peak-hold display resampler: sample memory, command sequencer, scan.
// Depends on phr_pkg, phr_div and assert_macros.svh.
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------
//  command  | start, busy, item                | beat taken when start & !busy
//  result   | done, result                     | one-cycle strobe, no backpressure
//  config   | cfg_wr_en, cfg_index, cfg_data   | written when cfg_wr_en is high
//
// A write never raises busy; an out-of-range beat gives its error result in the
// next cycle. Reads use the shared divider: an interpolated read divides to find
// its left sample (the last point returns that one), reads it and the next, scales
// their difference by the remainder and divides again; a max read divides twice for
// its bin bounds, then scans the bin. Each read's strobe rises in the same cycle as
// busy falls; the receiver cannot stall. The memory has no clearing pass.
`include "assert_macros.svh"

module peak_hold_display_resampler import phr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  phr_in_t           item,
	output logic              done,
	output phr_out_t          result,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_L_DIV1,
		ST_L_LAST,
		ST_L_RDA,
		ST_L_RDB,
		ST_L_ABS,
		ST_L_DIV2,
		ST_M_DIV1,
		ST_M_DIV2,
		ST_M_SCAN
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              in_count_q;
	logic [CNT_W-1:0]              out_count_q;
	logic [CNT_W-1:0]              nin;
	logic [CNT_W-1:0]              nout;
	logic [ADDR_W-1:0]             nin_m1;
	logic [ADDR_W-1:0]             nout_m1;

	logic signed [SAMPLE_BITS-1:0] sample_mem [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic                          rd_en;
	logic [ADDR_W-1:0]             rd_addr;
	logic                          accept;
	logic                          wr_ok;

	phr_div_req_t                  div_req;
	phr_div_rsp_t                  div_rsp;
	logic                          div_start_q;
	logic [DIV_W-1:0]              div_dividend_q;
	logic [DVSR_W-1:0]             div_divisor_q;

	logic [NUM_W-1:0]              num_q;
	logic [ADDR_W-1:0]             l_q;
	logic [DVSR_W-1:0]             r_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic                          neg_q;
	logic                          max_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              hi_q;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic                          pend_s1;
	logic                          done_q;
	phr_out_t                      result_q;

	logic                          l_at_end;
	logic                          rem_nz;
	logic signed [SAMPLE_BITS:0]   diff;
	logic [PROD_W-1:0]             prod_abs;
	logic [SAMPLE_BITS+1:0]        lin_mag;
	logic signed [SAMPLE_BITS+1:0] lin_sum;
	logic [DIV_W:0]                hi_full;

	assign nin     = eff_count(in_count_q);
	assign nout    = eff_count(out_count_q);
	assign nin_m1  = ADDR_W'(nin - 1'b1);
	assign nout_m1 = ADDR_W'(nout - 1'b1);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_ok  = accept && (item.cmd == CMD_WRITE) && ({1'b0, item.position} < nin);

	assign l_at_end = div_rsp.quotient >= DIV_W'(nin_m1);
	assign rem_nz   = (div_rsp.remainder != '0);
	assign diff     = (SAMPLE_BITS+1)'(rd_data_q) - (SAMPLE_BITS+1)'(a_q);
	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign lin_mag  = (SAMPLE_BITS+2)'(div_rsp.quotient[SAMPLE_BITS:0])
		+ (SAMPLE_BITS+2)'(neg_q && rem_nz);
	assign lin_sum  = neg_q ? ((SAMPLE_BITS+2)'(a_q) - $signed(lin_mag))
		: ((SAMPLE_BITS+2)'(a_q) + $signed(lin_mag));
	assign hi_full  = (DIV_W+1)'(div_rsp.quotient) + (DIV_W+1)'(rem_nz);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_L_DIV1: begin
				rd_en   = div_rsp.done;
				rd_addr = l_at_end ? nin_m1 : div_rsp.quotient[ADDR_W-1:0];
			end
			ST_L_RDA: begin
				rd_en   = 1'b1;
				rd_addr = l_q + 1'b1;
			end
			ST_M_SCAN: begin
				rd_en   = (cnt_q < hi_q);
				rd_addr = cnt_q[ADDR_W-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			sample_mem[item.position] <= item.sample;
		end
		if (rd_en) begin
			rd_data_q <= sample_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= INPUT_COUNT_RST;
			out_count_q <= OUTPUT_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_INPUT_COUNT:  in_count_q  <= cfg_data;
				CFG_OUTPUT_COUNT: out_count_q <= cfg_data;
				default:          in_count_q  <= in_count_q;
			endcase
		end
	end

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dividend_q;
	assign div_req.divisor  = div_divisor_q;

	phr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			div_start_q    <= 1'b0;
			div_dividend_q <= '0;
			div_divisor_q  <= '0;
			num_q          <= '0;
			l_q            <= '0;
			r_q            <= '0;
			a_q            <= '0;
			prod_q         <= '0;
			neg_q          <= 1'b0;
			max_q          <= 1'b0;
			cnt_q          <= '0;
			hi_q           <= '0;
			best_q         <= '0;
			pend_s1        <= 1'b0;
			done_q         <= 1'b0;
			result_q       <= '0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_WRITE) begin
							if (!wr_ok) begin
								result_q.value  <= '0;
								result_q.status <= STATUS_RANGE;
								done_q          <= 1'b1;
							end
						end else if ({1'b0, item.position} >= nout) begin
							result_q.value  <= '0;
							result_q.status <= STATUS_RANGE;
							done_q          <= 1'b1;
						end else begin
							num_q          <= NUM_W'(item.position) * NUM_W'(nin_m1);
							div_dividend_q <= DIV_W'(item.position) * DIV_W'(nin_m1);
							div_divisor_q  <= nout_m1;
							div_start_q    <= 1'b1;
							max_q          <= !(nout > nin);
							state_q        <= (nout > nin) ? ST_L_DIV1 : ST_M_DIV1;
						end
					end
				end
				ST_L_DIV1: begin
					if (div_rsp.done) begin
						l_q     <= div_rsp.quotient[ADDR_W-1:0];
						r_q     <= div_rsp.remainder;
						state_q <= l_at_end ? ST_L_LAST : ST_L_RDA;
					end
				end
				ST_L_LAST: begin
					result_q.value  <= rd_data_q;
					result_q.status <= STATUS_OK;
					done_q          <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_L_RDA: begin
					a_q     <= rd_data_q;
					state_q <= ST_L_RDB;
				end
				ST_L_RDB: begin
					prod_q  <= PROD_W'($signed({1'b0, r_q})) * PROD_W'(diff);
					state_q <= ST_L_ABS;
				end
				ST_L_ABS: begin
					neg_q          <= prod_q[PROD_W-1];
					div_dividend_q <= prod_abs[DIV_W-1:0];
					div_start_q    <= 1'b1;
					state_q        <= ST_L_DIV2;
				end
				ST_L_DIV2: begin
					if (div_rsp.done) begin
						result_q.value  <= lin_sum[SAMPLE_BITS-1:0];
						result_q.status <= STATUS_OK;
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				ST_M_DIV1: begin
					if (div_rsp.done) begin
						cnt_q          <= CNT_W'(div_rsp.quotient) + CNT_W'(rem_nz);
						div_dividend_q <= DIV_W'(num_q) + DIV_W'(nin_m1);
						div_start_q    <= 1'b1;
						state_q        <= ST_M_DIV2;
					end
				end
				ST_M_DIV2: begin
					if (div_rsp.done) begin
						hi_q    <= (hi_full > (DIV_W+1)'(nin)) ? nin : hi_full[CNT_W-1:0];
						best_q  <= '0;
						pend_s1 <= 1'b0;
						state_q <= ST_M_SCAN;
					end
				end
				ST_M_SCAN: begin
					if (pend_s1 && (rd_data_q > best_q)) begin
						best_q <= rd_data_q;
					end
					pend_s1 <= (cnt_q < hi_q);
					if (cnt_q < hi_q) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!pend_s1) begin
						result_q.value  <= best_q;
						result_q.status <= STATUS_OK;
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PHR_ASSERT_IMPLY(a_idle_div_quiet, state_q == ST_IDLE, !div_rsp.busy, "divider busy while idle")
	`PHR_ASSERT_IMPLY(a_err_zero, done_q && result_q.status, result_q.value == '0, "error beat with nonzero value")
	`PHR_ASSERT_IMPLY(a_max_nonneg, done_q && max_q && !result_q.status, !result_q.value[SAMPLE_BITS-1], "negative peak value")

endmodule

/* test/resampler_checker.sv */
// Checker for the peak-hold display resampler: tracks the count registers and the sample row,
// predicts each result from the command beats it sees and compares it with the result port.
// Depends on phr_pkg for the beat types, widths and codes.
module resampler_checker import phr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  phr_in_t          item,
	input  logic             done,
	input  phr_out_t         result,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CNT_W-1:0]              in_count_reg;
	logic [CNT_W-1:0]              out_count_reg;
	logic signed [SAMPLE_BITS-1:0] row [MAX_SAMPLES];
	phr_out_t                      point_q [$];
	int                            errors = 0;
	int                            result_no = 0;

	function automatic longint sat_count(logic [CNT_W-1:0] c);
		if (c < 2) begin
			return 2;
		end
		if (c > MAX_SAMPLES) begin
			return MAX_SAMPLES;
		end
		return c;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] interp_point(longint k, longint nin,
		longint nout);
		longint num, d, l, rem, a, b, prod, q;
		num = k * (nin - 1);
		d = nout - 1;
		l = num / d;
		rem = num % d;
		if (l >= nin - 1) begin
			return row[nin - 1];
		end
		a = row[l];
		b = row[l + 1];
		prod = rem * (b - a);
		q = prod / d;
		if ((prod % d) != 0 && prod < 0) begin
			q = q - 1;
		end
		return SAMPLE_BITS'(a + q);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] peak_point(longint k, longint nin,
		longint nout);
		longint sn, sd, lo, hi, best;
		sn = nin - 1;
		sd = nout - 1;
		lo = (k * sn + sd - 1) / sd;
		hi = ((k + 1) * sn + sd - 1) / sd;
		best = 0;
		if (hi > nin) begin
			hi = nin;
		end
		for (longint i = lo; i < hi; i++) begin
			if (row[i] > best) begin
				best = row[i];
			end
		end
		return SAMPLE_BITS'(best);
	endfunction

	// Returns 1 when the beat produces a result, which is then in pt.
	function automatic bit predict(phr_in_t b, output phr_out_t pt);
		longint nin, nout, k;
		nin = sat_count(in_count_reg);
		nout = sat_count(out_count_reg);
		k = b.position;
		pt.value = '0;
		pt.status = STATUS_RANGE;
		if (b.cmd == CMD_WRITE) begin
			if (k >= nin) begin
				return 1;
			end
			row[k] = b.sample;
			return 0;
		end
		if (k >= nout) begin
			return 1;
		end
		pt.status = STATUS_OK;
		if (nout > nin) begin
			pt.value = interp_point(k, nin, nout);
		end else begin
			pt.value = peak_point(k, nin, nout);
		end
		return 1;
	endfunction

	task automatic report(string msg);
		if (errors < 40) begin
			$display("%0t ns resampler check: %s", $time, msg);
		end
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		phr_out_t want;
		if (!arst_n) begin
			in_count_reg = INPUT_COUNT_RST;
			out_count_reg = OUTPUT_COUNT_RST;
			point_q.delete();
		end else begin
			if (done) begin
				result_no++;
				if (point_q.size() == 0) begin
					report($sformatf("result %0d (%h) arrived with nothing expected",
						result_no, result));
				end else begin
					want = point_q.pop_front();
					if (result.value !== want.value) begin
						report($sformatf("result %0d value %h, expected %h", result_no,
							result.value, want.value));
					end
					if (result.status !== want.status) begin
						report($sformatf("result %0d status %b, expected %b", result_no,
							result.status, want.status));
					end
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_INPUT_COUNT) begin
					in_count_reg = cfg_data;
				end else begin
					out_count_reg = cfg_data;
				end
			end
			if (start && !busy) begin
				if (predict(item, want)) begin
					point_q.push_back(want);
				end
			end
		end
		pending <= point_q.size();
		fail_count <= errors;
	end

endmodule

/* test/testbench.sv */
// Top of the resampler testbench: clock, reset, command beats, count register writes and verdict.
// Instantiates peak_hold_display_resampler and resampler_checker; depends on phr_pkg.
module testbench import phr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_COUNT    = 750;
	localparam int FILL_CAP      = 256;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	phr_in_t          item;
	logic             done;
	phr_out_t         result;
	logic             cfg_wr_en;
	logic             cfg_index;
	logic [CNT_W-1:0] cfg_data;
	int               fail_count;
	int               pending;

	bit          filled [MAX_SAMPLES];
	int unsigned nin_use = INPUT_COUNT_RST;
	int unsigned nout_use = OUTPUT_COUNT_RST;
	bit          no_idle = 1'b0;
	int          sent_items = 0;

	peak_hold_display_resampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	resampler_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned in_use(int unsigned raw);
		if (raw < 2) begin
			return 2;
		end
		if (raw > MAX_SAMPLES) begin
			return MAX_SAMPLES;
		end
		return raw;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned pick_count();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return 1;
			2: return 8191;
			3: return 4096;
			4: return $urandom_range(4097, 8191);
			5: return $urandom_range(2, 4096);
			6: return 2;
			default: return $urandom_range(2, 40);
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Number of samples that still have to be written before point k can be read.
	function automatic int fill_cost(int unsigned k);
		longint kk, sn, sd, lo, hi;
		int cost;
		kk = k;
		sn = nin_use - 1;
		sd = nout_use - 1;
		cost = 0;
		lo = 0;
		hi = 0;
		if (k < nout_use) begin
			if (nout_use > nin_use) begin
				lo = kk * sn / sd;
				if (lo >= sn) begin
					lo = sn;
					hi = sn + 1;
				end else begin
					hi = lo + 2;
				end
			end else begin
				lo = (kk * sn + sd - 1) / sd;
				hi = ((kk + 1) * sn + sd - 1) / sd;
				if (hi > nin_use) begin
					hi = nin_use;
				end
			end
		end
		for (longint i = lo; i < hi; i++) begin
			if (!filled[i]) begin
				cost++;
			end
		end
		return cost;
	endfunction

	task automatic send(logic cmd, int unsigned pos, logic [SAMPLE_BITS-1:0] smp);
		phr_in_t b;
		int gap;
		b.cmd = cmd;
		b.position = pos[ADDR_W-1:0];
		b.sample = smp;
		start <= 1'b1;
		item <= b;
		do @(posedge clk); while (busy);
		sent_items++;
		if (cmd == CMD_WRITE && pos < nin_use) begin
			filled[pos] = 1'b1;
		end
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			item <= phr_in_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic fill(longint lo, longint hi);
		for (longint i = lo; i <= hi; i++) begin
			if (!filled[i]) begin
				send(CMD_WRITE, i, rand_sample());
			end
		end
	endtask

	// Writes every sample the point depends on before asking for it.
	task automatic read_point(int unsigned k);
		longint kk, sn, sd, l, lo, hi;
		kk = k;
		if (k < nout_use) begin
			sn = nin_use - 1;
			sd = nout_use - 1;
			if (nout_use > nin_use) begin
				l = kk * sn / sd;
				if (l >= sn) begin
					fill(sn, sn);
				end else begin
					fill(l, l + 1);
				end
			end else begin
				lo = (kk * sn + sd - 1) / sd;
				hi = ((kk + 1) * sn + sd - 1) / sd;
				if (hi > nin_use) begin
					hi = nin_use;
				end
				fill(lo, hi - 1);
			end
		end
		send(CMD_READ, k, rand_sample());
	endtask

	// Falls back to the last point, which needs one sample, when more than FILL_CAP samples of point k are unwritten.
	task automatic read_capped(int unsigned k);
		if (fill_cost(k) > FILL_CAP) begin
			read_point(nout_use - 1);
		end else begin
			read_point(k);
		end
	endtask

	task automatic set_counts(int unsigned in_raw, int unsigned out_raw);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_INPUT_COUNT;
		cfg_data <= CNT_W'(in_raw);
		@(posedge clk);
		cfg_index <= CFG_OUTPUT_COUNT;
		cfg_data <= CNT_W'(out_raw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		nin_use = in_use(in_raw);
		nout_use = in_use(out_raw);
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || cfg_wr_en || !arst_n) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int n;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_INPUT_COUNT;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset counts give peak mode with a few samples per bin.
		send(CMD_WRITE, 0, 16'h7fff);
		send(CMD_WRITE, 1, 16'h8000);
		send(CMD_WRITE, 2, 16'hffff);
		send(CMD_WRITE, 3, 16'h0100);
		send(CMD_WRITE, 4, 16'hfffb);
		send(CMD_WRITE, 4095, 16'h8000);
		read_point(0);
		read_point(1023);
		read_point(1024);
		read_point(4095);

		set_counts(4, 7);
		send(CMD_WRITE, 0, 16'h8000);
		send(CMD_WRITE, 1, 16'h7fff);
		send(CMD_WRITE, 2, 16'h0000);
		send(CMD_WRITE, 3, 16'hffff);
		for (int k = 0; k <= 7; k++) begin
			read_point(k);
		end
		send(CMD_WRITE, 4, 16'h1234);
		send(CMD_WRITE, 4095, 16'h5a5a);

		set_counts(0, 8191);
		read_point(4095);
		read_point(2048);
		set_counts(8191, 1);
		read_point(1);

		while (sent_items < ITEM_COUNT) begin
			set_counts(pick_count(), pick_count());
			no_idle = ($urandom_range(0, 3) == 0);
			if (nin_use > 64 * nout_use) begin
				n = $urandom_range(3, 6);
			end else begin
				n = $urandom_range(15, 40);
			end
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					read_point(nout_use - 1);
				end else if (r < 8) begin
					read_capped(0);
				end else if (r < 50) begin
					read_capped($urandom_range(0, nout_use - 1));
				end else if (r < 78) begin
					send(CMD_WRITE, $urandom_range(0, nin_use - 1), rand_sample());
				end else if (r < 89) begin
					if (nout_use < MAX_SAMPLES) begin
						send(CMD_READ, $urandom_range(nout_use, MAX_SAMPLES - 1), rand_sample());
					end else begin
						read_capped($urandom_range(0, nout_use - 1));
					end
				end else begin
					if (nin_use < MAX_SAMPLES) begin
						send(CMD_WRITE, $urandom_range(nin_use, MAX_SAMPLES - 1), rand_sample());
					end else begin
						send(CMD_WRITE, $urandom_range(0, nin_use - 1), rand_sample());
					end
				end
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/phr_pkg.sv
design/phr_div.sv
design/peak_hold_display_resampler.sv
test/resampler_checker.sv
test/testbench.sv
